/* hdl/limit_order_book_matcher_assert.svh */
// Assertion macros for the order book matcher
`ifndef LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
// same-cycle implication, clocked on clk, off during rst
`define LOBM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lobm: same-cycle check failed");
// next-cycle implication, clocked on clk, off during rst
`define LOBM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lobm: next-cycle check failed");
`endif

/* hdl/lobm_pkg.sv */
// Types and codes shared by the order book matcher
package lobm_pkg;

  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_POOL_FULL = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  localparam logic MODE_LIMIT  = 1'b0;
  localparam logic MODE_CANCEL = 1'b1;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LV_SCAN,
    S_MK_FILL,
    S_MK_FREE,
    S_REST,
    S_REST_WR,
    S_REST_LINK,
    S_C_ID,
    S_C_SLOT,
    S_C_LEVEL,
    S_FINISH
  } state_t;

endpackage

/* hdl/lobm_ram.sv */
// Generic single-write, single-read RAM with registered read data
module lobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/limit_order_book_matcher.sv */
// Price-time priority limit order book matcher, top level
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid in_ready mode order_id side price quantity | into block
//  out     | out_valid out_ready status filled_qty rested_qty   | out of block
//
// Flow: one item at a time; a cancel reads the id map, the slot and the level
// (an unknown id ends after the id map), a limit order scans price levels,
// fills and frees each maker emptied, and then rests the remainder or drops it.
// Level scan and maker walk each wait on one RAM read.
// Reset: a clearing pass empties the id map and the level table; in_ready stays
// low meanwhile.
// Stalls: a finished result waits in the output register while the next
// transaction is accepted; a second result waits until out_ready.
`include "limit_order_book_matcher_assert.svh"
module limit_order_book_matcher
  import lobm_pkg::*;
#(
  parameter int POOL_SLOTS  = 1024,
  parameter int PRICE_TICKS = 1024,
  parameter int ID_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [15:0] order_id,
  input  logic        side,
  input  logic [9:0]  price,
  input  logic [31:0] quantity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] filled_qty,
  output logic [31:0] rested_qty
);

  localparam int AW = $clog2(POOL_SLOTS);
  localparam int SW = AW + 1;
  localparam logic [SW-1:0] NIL = SW'(POOL_SLOTS);
  localparam int PB = $clog2(PRICE_TICKS);
  localparam int LAW = PB + 1;
  localparam int LV_DEPTH = 2 * (1 << PB);
  localparam int ID_DEPTH = 1 << ID_BITS;
  localparam int CW = (ID_BITS > LAW) ? ID_BITS : LAW;
  localparam logic [PB-1:0] PMAX = PB'(PRICE_TICKS - 1);
  localparam int SDW = ID_BITS + PB + 32 + 1;

  state_t state, state_next;
  logic [CW-1:0] clr, clr_next;
  logic [SW-1:0] fh, fh_next, hw, hw_next;
  logic [SW-1:0] cur, cur_next, lvh, lvh_next, lvt, lvt_next;
  logic [ID_BITS-1:0] r_id, r_id_next, mid, mid_next;
  logic r_side, r_side_next;
  logic [PB-1:0] r_price, r_price_next, p, p_next;
  logic [31:0] rem, rem_next, filled, filled_next, rested, rested_next;
  logic [1:0] stat, stat_next;
  logic out_valid_next;
  logic [1:0] status_next;
  logic [31:0] filled_qty_next, rested_qty_next;

  logic sd_we;
  logic [AW-1:0] sd_waddr, sd_raddr;
  logic [SDW-1:0] sd_wdata, sd_rdata;
  logic nx_we;
  logic [AW-1:0] nx_waddr, nx_raddr;
  logic [SW-1:0] nx_wdata, nx_rdata;
  logic pv_we;
  logic [AW-1:0] pv_waddr, pv_raddr;
  logic [SW-1:0] pv_wdata, pv_rdata;
  logic lv_we;
  logic [LAW-1:0] lv_waddr, lv_raddr;
  logic [2*SW-1:0] lv_wdata, lv_rdata;
  logic im_we;
  logic [ID_BITS-1:0] im_waddr, im_raddr;
  logic [SW-1:0] im_wdata, im_rdata;

  logic [ID_BITS-1:0] sd_id;
  logic [PB-1:0] sd_price, price_sat, p_start, p_adv;
  logic [31:0] sd_qty, fill_m, qty_left;
  logic sd_side, at_lim;
  logic [SW-1:0] lv_head, lv_tail;

  lobm_ram #(.WIDTH(SDW), .DEPTH(POOL_SLOTS)) u_slot_data (
    .clk(clk), .we(sd_we), .waddr(sd_waddr), .wdata(sd_wdata),
    .raddr(sd_raddr), .rdata(sd_rdata));
  lobm_ram #(.WIDTH(SW), .DEPTH(POOL_SLOTS)) u_slot_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rdata));
  lobm_ram #(.WIDTH(SW), .DEPTH(POOL_SLOTS)) u_slot_prev (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(pv_raddr), .rdata(pv_rdata));
  lobm_ram #(.WIDTH(2*SW), .DEPTH(LV_DEPTH)) u_level (
    .clk(clk), .we(lv_we), .waddr(lv_waddr), .wdata(lv_wdata),
    .raddr(lv_raddr), .rdata(lv_rdata));
  lobm_ram #(.WIDTH(SW), .DEPTH(ID_DEPTH)) u_id_map (
    .clk(clk), .we(im_we), .waddr(im_waddr), .wdata(im_wdata),
    .raddr(im_raddr), .rdata(im_rdata));

  assign sd_id    = sd_rdata[SDW-1 -: ID_BITS];
  assign sd_price = sd_rdata[33 +: PB];
  assign sd_qty   = sd_rdata[1 +: 32];
  assign sd_side  = sd_rdata[0];
  assign lv_head  = lv_rdata[2*SW-1 -: SW];
  assign lv_tail  = lv_rdata[SW-1:0];
  assign price_sat = (32'(price) >= PRICE_TICKS) ? PMAX : PB'(price);
  assign p_start  = (side == SIDE_BUY) ? '0 : PMAX;
  assign p_adv    = (r_side == SIDE_BUY) ? PB'(p + 1'b1) : PB'(p - 1'b1);
  assign at_lim   = (p == r_price);
  assign fill_m   = (rem < sd_qty) ? rem : sd_qty;
  assign qty_left = sd_qty - fill_m;
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      fh        <= '0;
      hw        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr       <= clr_next;
      fh        <= fh_next;
      hw        <= hw_next;
      out_valid <= out_valid_next;
    end
    cur        <= cur_next;
    lvh        <= lvh_next;
    lvt        <= lvt_next;
    r_id       <= r_id_next;
    mid        <= mid_next;
    r_side     <= r_side_next;
    r_price    <= r_price_next;
    p          <= p_next;
    rem        <= rem_next;
    filled     <= filled_next;
    rested     <= rested_next;
    stat       <= stat_next;
    status     <= status_next;
    filled_qty <= filled_qty_next;
    rested_qty <= rested_qty_next;
  end

  always_comb begin
    state_next      = state;
    clr_next        = clr;
    fh_next         = fh;
    hw_next         = hw;
    cur_next        = cur;
    lvh_next        = lvh;
    lvt_next        = lvt;
    r_id_next       = r_id;
    mid_next        = mid;
    r_side_next     = r_side;
    r_price_next    = r_price;
    p_next          = p;
    rem_next        = rem;
    filled_next     = filled;
    rested_next     = rested;
    stat_next       = stat;
    out_valid_next  = out_valid && !out_ready;
    status_next     = status;
    filled_qty_next = filled_qty;
    rested_qty_next = rested_qty;
    sd_we = 1'b0; sd_waddr = cur[AW-1:0]; sd_wdata = '0; sd_raddr = cur[AW-1:0];
    nx_we = 1'b0; nx_waddr = cur[AW-1:0]; nx_wdata = NIL; nx_raddr = cur[AW-1:0];
    pv_we = 1'b0; pv_waddr = cur[AW-1:0]; pv_wdata = NIL; pv_raddr = cur[AW-1:0];
    lv_we = 1'b0; lv_waddr = {~r_side, p}; lv_wdata = {lvh, lvt}; lv_raddr = {~r_side, p};
    im_we = 1'b0; im_waddr = r_id; im_wdata = NIL; im_raddr = r_id;
    case (state)
      S_CLEAR: begin
        im_we    = 1'b1;
        im_waddr = clr[ID_BITS-1:0];
        lv_we    = 1'b1;
        lv_waddr = clr[LAW-1:0];
        lv_wdata = {NIL, NIL};
        clr_next = CW'(clr + 1'b1);
        if (&clr) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          r_id_next    = ID_BITS'(order_id);
          r_side_next  = side;
          r_price_next = price_sat;
          rem_next     = quantity;
          filled_next  = '0;
          rested_next  = '0;
          stat_next    = STAT_DONE;
          if (mode == MODE_CANCEL) begin
            im_raddr   = ID_BITS'(order_id);
            state_next = S_C_ID;
          end else if (quantity == '0) begin
            state_next = S_FINISH;
          end else begin
            p_next     = p_start;
            lv_raddr   = {~side, p_start};
            state_next = S_LV_SCAN;
          end
        end
      end
      S_LV_SCAN: begin
        if (lv_head == NIL) begin
          if (at_lim) begin
            state_next = S_REST;
          end else begin
            p_next   = p_adv;
            lv_raddr = {~r_side, p_adv};
          end
        end else begin
          cur_next   = lv_head;
          lvh_next   = lv_head;
          lvt_next   = lv_tail;
          sd_raddr   = lv_head[AW-1:0];
          nx_raddr   = lv_head[AW-1:0];
          state_next = S_MK_FILL;
        end
      end
      S_MK_FILL: begin
        rem_next    = rem - fill_m;
        filled_next = filled + fill_m;
        if (qty_left != '0) begin
          sd_we      = 1'b1;
          sd_wdata   = {sd_id, sd_price, qty_left, sd_side};
          state_next = S_REST;
        end else begin
          mid_next = sd_id;
          im_raddr = sd_id;
          nx_we    = 1'b1;
          nx_wdata = fh;
          fh_next  = cur;
          if (nx_rdata != NIL) begin
            pv_we    = 1'b1;
            pv_waddr = nx_rdata[AW-1:0];
          end else begin
            lvt_next = NIL;
          end
          lvh_next   = nx_rdata;
          state_next = S_MK_FREE;
        end
      end
      S_MK_FREE: begin
        if (im_rdata == cur) begin
          im_we    = 1'b1;
          im_waddr = mid;
        end
        lv_we = 1'b1;
        if (rem == '0) begin
          state_next = S_REST;
        end else if (lvh != NIL) begin
          cur_next   = lvh;
          sd_raddr   = lvh[AW-1:0];
          nx_raddr   = lvh[AW-1:0];
          state_next = S_MK_FILL;
        end else if (at_lim) begin
          state_next = S_REST;
        end else begin
          p_next     = p_adv;
          lv_raddr   = {~r_side, p_adv};
          state_next = S_LV_SCAN;
        end
      end
      S_REST: begin
        if (rem == '0) begin
          state_next = S_FINISH;
        end else if (fh == NIL) begin
          stat_next  = STAT_POOL_FULL;
          state_next = S_FINISH;
        end else begin
          cur_next   = fh;
          nx_raddr   = fh[AW-1:0];
          lv_raddr   = {r_side, r_price};
          state_next = S_REST_WR;
        end
      end
      S_REST_WR: begin
        if (cur >= hw) begin
          fh_next = SW'(cur + 1'b1);
          hw_next = SW'(cur + 1'b1);
        end else begin
          fh_next = nx_rdata;
        end
        sd_we       = 1'b1;
        sd_wdata    = {r_id, r_price, rem, r_side};
        nx_we       = 1'b1;
        pv_we       = 1'b1;
        pv_wdata    = (lv_head == NIL) ? NIL : lv_tail;
        lv_we       = 1'b1;
        lv_waddr    = {r_side, r_price};
        lv_wdata    = (lv_head == NIL) ? {cur, cur} : {lv_head, cur};
        im_we       = 1'b1;
        im_wdata    = cur;
        rested_next = rem;
        lvt_next    = lv_tail;
        state_next  = (lv_head == NIL) ? S_FINISH : S_REST_LINK;
      end
      S_REST_LINK: begin
        nx_we      = 1'b1;
        nx_waddr   = lvt[AW-1:0];
        nx_wdata   = cur;
        state_next = S_FINISH;
      end
      S_C_ID: begin
        if (im_rdata >= NIL) begin
          stat_next  = STAT_NOT_FOUND;
          state_next = S_FINISH;
        end else begin
          cur_next   = im_rdata;
          sd_raddr   = im_rdata[AW-1:0];
          nx_raddr   = im_rdata[AW-1:0];
          pv_raddr   = im_rdata[AW-1:0];
          state_next = S_C_SLOT;
        end
      end
      S_C_SLOT: begin
        if (pv_rdata != NIL) begin
          nx_we    = 1'b1;
          nx_waddr = pv_rdata[AW-1:0];
          nx_wdata = nx_rdata;
        end
        if (nx_rdata != NIL) begin
          pv_we    = 1'b1;
          pv_waddr = nx_rdata[AW-1:0];
          pv_wdata = pv_rdata;
        end
        im_we       = 1'b1;
        lv_raddr    = {sd_side, sd_price};
        lvh_next    = nx_rdata;
        lvt_next    = pv_rdata;
        r_side_next = sd_side;
        p_next      = sd_price;
        state_next  = S_C_LEVEL;
      end
      S_C_LEVEL: begin
        lv_we      = 1'b1;
        lv_waddr   = {r_side, p};
        lv_wdata   = {(lv_head == cur) ? lvh : lv_head, (lv_tail == cur) ? lvt : lv_tail};
        nx_we      = 1'b1;
        nx_wdata   = fh;
        fh_next    = cur;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          out_valid_next  = 1'b1;
          status_next     = stat;
          filled_qty_next = filled;
          rested_qty_next = rested;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `LOBM_ASSERT_IMP(a_free_below_mark, 1'b1, fh <= hw)
  `LOBM_ASSERT_IMP(a_rest_only_done, out_valid && rested_qty != '0, status == STAT_DONE)
  `LOBM_ASSERT_IMP(a_miss_empty, out_valid && status == STAT_NOT_FOUND,
                   filled_qty == '0 && rested_qty == '0)
  `LOBM_ASSERT_NXT(a_partial_ends, state == S_MK_FILL && qty_left != '0, rem == '0)

endmodule
